@@ hdl/rvlsu_pkg.sv @@
// shared types and constants for the rv64 load/store unit
`timescale 1ns / 1ps
`default_nettype none

package rvlsu_pkg;

  // default memory size in address bits
  localparam int unsigned MEM_ADDR_BITS_DEF = 16;

  // bytes per memory row, one byte lane per bank
  localparam int unsigned LANES     = 8;
  localparam int unsigned LANE_BITS = 3;

  // request kinds
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_STORE = 2'd1,
    REQ_FENCE = 2'd2
  } req_t;

  // funct3 codes for loads and stores
  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_D  = 3'd3;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;
  localparam logic [2:0] F3_WU = 3'd6;

endpackage

`default_nettype wire

@@ hdl/rv64_load_store_unit_top.sv @@
// rv64 load/store unit: banked byte memory with misaligned access
`timescale 1ns / 1ps
`default_nettype none

// channel    direction  signals                                   transfer
// request    in         start, busy, req_type, instruction,       start & !busy
//                       base_value, store_value
// result     out        done, write_reg_valid, dest_reg,          done (one cycle)
//                       write_value
//
// each request passes through address and memory access, byte
// alignment and extension, then the result register; a new request is
// taken in the cycle its predecessor's result is shown, so requests do
// not overlap. the memory is eight byte-wide banks, one read or write
// port each, so any misaligned access is done in a single memory access.
// after reset a clearing pass zeroes one row of all banks per cycle,
// over all 2^(MEM_ADDR_BITS-3) rows (8192 at the default), with busy high.
// the receiver cannot stall: every result is shown on done for one cycle.

module rv64_load_store_unit_top #(
  parameter int unsigned MEM_ADDR_BITS = rvlsu_pkg::MEM_ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] instruction,
  input  wire logic [63:0] base_value,
  input  wire logic [63:0] store_value,
  output logic             done,
  output logic             write_reg_valid,
  output logic [4:0]       dest_reg,
  output logic [63:0]      write_value
);

  localparam int unsigned LB   = rvlsu_pkg::LANE_BITS;
  localparam int unsigned NL   = rvlsu_pkg::LANES;
  localparam int unsigned RB   = MEM_ADDR_BITS - LB;
  localparam int unsigned ROWS = 1 << RB;

  // clearing pass
  logic          clearing;
  logic [RB-1:0] clr_row;

  // stage 1: address and memory access
  logic              s1_valid;
  rvlsu_pkg::req_t   s1_req;
  logic [31:0]       s1_ins;
  logic [63:0]       s1_base;
  logic [63:0]       s1_data;

  // stage 2: alignment and extension
  logic              s2_valid;
  logic              s2_load;
  logic [2:0]        s2_f3;
  logic [4:0]        s2_rd;
  logic [LB-1:0]     s2_off;

  logic accept;
  assign busy   = clearing | s1_valid | s2_valid;
  assign accept = start & ~busy;

  // effective address
  logic [11:0]              imm12;
  logic [63:0]              imm64;
  logic [MEM_ADDR_BITS-1:0] addr;
  logic [LB-1:0]            off;
  logic [RB-1:0]            row;
  logic [2:0]               s1_f3;
  logic                     s1_store_en;

  always_comb begin
    s1_f3 = s1_ins[14:12];
    if (s1_req == rvlsu_pkg::REQ_STORE) begin
      imm12 = {s1_ins[31:25], s1_ins[11:7]};
    end else begin
      imm12 = s1_ins[31:20];
    end
    imm64       = {{52{imm12[11]}}, imm12};
    addr        = s1_base[MEM_ADDR_BITS-1:0] + imm64[MEM_ADDR_BITS-1:0];
    off         = addr[LB-1:0];
    row         = addr[MEM_ADDR_BITS-1:LB];
    s1_store_en = s1_valid && (s1_req == rvlsu_pkg::REQ_STORE) && !s1_f3[2];
  end

  // per-bank addressing: bank b holds byte (b - off) of the access,
  // taken from the next row when the access wraps past lane seven
  logic [RB-1:0]     bank_row [NL];
  logic              bank_we  [NL];
  logic [7:0]        bank_wd  [NL];
  logic [NL-1:0][7:0] rd_bytes;

  always_comb begin
    logic [LB-1:0] k;
    logic [3:0]    nbytes;
    nbytes = 4'd1 << s1_f3[1:0];
    for (int b = 0; b < NL; b++) begin
      k = LB'(b) - off;
      if (clearing) begin
        bank_row[b] = clr_row;
        bank_we[b]  = 1'b1;
        bank_wd[b]  = 8'h00;
      end else begin
        bank_row[b] = row + {{(RB-1){1'b0}}, (LB'(b) < off)};
        bank_we[b]  = s1_store_en && ({1'b0, k} < nbytes);
        bank_wd[b]  = s1_data[8*k +: 8];
      end
    end
  end

  for (genvar b = 0; b < NL; b++) begin : g_bank
    logic [7:0] mem_q [ROWS];
    logic [7:0] rdq;

    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        mem_q[bank_row[b]] <= bank_wd[b];
      end
      rdq <= mem_q[bank_row[b]];
    end

    assign rd_bytes[b] = rdq;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_row <= clr_row + RB'(1);
        if (clr_row == {RB{1'b1}}) begin
          clearing <= 1'b0;
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req  <= rvlsu_pkg::req_t'(req_type);
      s1_ins  <= instruction;
      s1_base <= base_value;
      s1_data <= store_value;
    end
    if (s1_valid) begin
      s2_load <= (s1_req == rvlsu_pkg::REQ_LOAD);
      s2_f3   <= s1_f3;
      s2_rd   <= s1_ins[11:7];
      s2_off  <= off;
    end
  end

  // gather bytes in access order, then extend
  logic [63:0] raw;
  logic [63:0] ld_value;

  always_comb begin
    logic [LB-1:0] idx;
    for (int k = 0; k < NL; k++) begin
      idx           = s2_off + LB'(k);
      raw[8*k +: 8] = rd_bytes[idx];
    end
    case (s2_f3)
      rvlsu_pkg::F3_B:  ld_value = {{56{raw[7]}}, raw[7:0]};
      rvlsu_pkg::F3_H:  ld_value = {{48{raw[15]}}, raw[15:0]};
      rvlsu_pkg::F3_W:  ld_value = {{32{raw[31]}}, raw[31:0]};
      rvlsu_pkg::F3_D:  ld_value = raw;
      rvlsu_pkg::F3_BU: ld_value = {56'd0, raw[7:0]};
      rvlsu_pkg::F3_HU: ld_value = {48'd0, raw[15:0]};
      rvlsu_pkg::F3_WU: ld_value = {32'd0, raw[31:0]};
      default:          ld_value = 64'd0;
    endcase
  end

  // result register, loaded with done and held until the next result
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      write_reg_valid <= s2_load;
      dest_reg        <= s2_load ? s2_rd : 5'd0;
      write_value     <= s2_load ? ld_value : 64'd0;
    end
  end

endmodule

`default_nettype wire
